// ===== rtl/brb_pkg.sv =====
package brb_pkg;

  localparam int BYTE_W   = 8;
  localparam int OFF_W    = 12;
  localparam int LEN_W    = 7;
  localparam int SIZE_W   = 13;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 13;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } brb_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } brb_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR,
    S_CHK,
    S_LEN,
    S_RUN,
    S_END
  } brb_state_t;

endpackage

// ===== rtl/byte_ring_buffer_with_offset_peek_core.sv =====
// Channel   | Handshake                 | Contents
// ----------+---------------------------+--------------------------------------------
// input     | start & !busy             | in_operation, in_wr_byte, in_rd_offset,
//           |                           | in_rd_length, in_rd_delete
// result    | out_valid, one cycle      | out_rd_byte, out_status, out_last,
//           |                           | out_is_empty, out_has_space, out_fill_count
// config    | cfg_valid & cfg_ready     | cfg_buffer_size
//
// A write holds busy through its write state and strobes its result in the next cycle,
// when busy is low again, so a new item can go in while that result strobes.
// A read holds busy while it checks the request and forms the start index, clamps the
// length, issues one store read per byte of the run and then retires the run; its last
// byte strobes in the first idle cycle. A refused read returns to idle from the check
// state. Reset is synchronous and active low; the store is not cleared. No result stalls.
module byte_ring_buffer_with_offset_peek_core #(
  parameter int DEPTH   = 4096,
  parameter int MAX_RUN = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [brb_pkg::BYTE_W-1:0]    in_wr_byte,
  input  logic [brb_pkg::OFF_W-1:0]     in_rd_offset,
  input  logic [brb_pkg::LEN_W-1:0]     in_rd_length,
  input  logic                          in_rd_delete,
  output logic                          out_valid,
  output logic [brb_pkg::BYTE_W-1:0]    out_rd_byte,
  output brb_pkg::brb_status_t          out_status,
  output logic                          out_last,
  output logic                          out_is_empty,
  output logic                          out_has_space,
  output logic [brb_pkg::FILL_W-1:0]    out_fill_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [brb_pkg::SIZE_W-1:0]    cfg_buffer_size
);
  import brb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = $clog2(MAX_RUN + 1);
  localparam int UW = ((CW > OFF_W) ? CW : OFF_W) + 1;

  // Sequencer and ring pointers. The tail index points at the oldest byte,
  // so the start of a peek is simply tail plus offset, wrapped once.
  brb_state_t      state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   size_r, size_nxt;

  // Latched request.
  brb_op_t           op_r, op_nxt;
  logic [BYTE_W-1:0] wbyte_r, wbyte_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              del_r, del_nxt;

  // Run bookkeeping.
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   avail_r, avail_nxt;
  logic [RW-1:0]   run_len_r, run_len_nxt;
  logic [RW-1:0]   rem_r, rem_nxt;
  logic            iss_v_r, iss_v_nxt;
  logic            iss_last_r, iss_last_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_rd_byte_r, out_rd_byte_nxt;
  brb_status_t       out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_is_empty_r, out_is_empty_nxt;
  logic              out_has_space_r, out_has_space_nxt;
  logic [FILL_W-1:0] out_fill_count_r, out_fill_count_nxt;

  // Shared wrap-around adder.
  logic [AW-1:0]   wa_a;
  logic [UW-1:0]   wa_b;
  logic [AW-1:0]   wa_y;

  // Store.
  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [BYTE_W-1:0] ram_rd_data;

  logic accept;
  logic cfg_fire;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign accept    = start && !busy;
  assign cfg_fire  = cfg_valid && cfg_ready;

  brb_wrap_add #(
    .AW (AW),
    .CW (CW),
    .UW (UW)
  ) u_wrap_add (
    .a    (wa_a),
    .b    (wa_b),
    .size (size_r),
    .y    (wa_y)
  );

  brb_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (head_r),
    .wr_data (wbyte_r),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r),
    .rd_data (ram_rd_data)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (brb_op_t'(in_operation) == OP_READ) ? S_CHK : S_WR;
        end
      end
      S_WR: begin
        state_nxt = S_IDLE;
      end
      S_CHK: begin
        if ((count_r == '0) || (UW'(off_r) >= UW'(count_r))) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (rem_r == RW'(1)) begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    logic [LEN_W-1:0] len_q;
    logic [RW-1:0]    len_c;
    logic             full;
    logic             emit;
    logic [CW-1:0]    emit_cnt;

    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    size_nxt    = size_r;
    op_nxt      = op_r;
    wbyte_nxt   = wbyte_r;
    off_nxt     = off_r;
    len_nxt     = len_r;
    del_nxt     = del_r;
    idx_nxt     = idx_r;
    avail_nxt   = avail_r;
    run_len_nxt = run_len_r;
    rem_nxt     = rem_r;

    out_valid_nxt      = 1'b0;
    out_rd_byte_nxt    = out_rd_byte_r;
    out_status_nxt     = out_status_r;
    out_last_nxt       = out_last_r;
    out_is_empty_nxt   = out_is_empty_r;
    out_has_space_nxt  = out_has_space_r;
    out_fill_count_nxt = out_fill_count_r;

    ram_wr_en = 1'b0;
    ram_rd_en = 1'b0;
    wa_a      = head_r;
    wa_b      = UW'(1);
    emit      = 1'b0;
    emit_cnt  = count_r;
    full      = (count_r >= size_r);

    // A requested length of zero counts as one; long requests saturate,
    // then the run is clamped to the bytes past the offset.
    if (len_r == '0) begin
      len_q = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_RUN)) begin
      len_q = LEN_W'(MAX_RUN);
    end else begin
      len_q = len_r;
    end
    if (UW'(avail_r) < UW'(len_q)) begin
      len_c = RW'(avail_r);
    end else begin
      len_c = RW'(len_q);
    end

    if (accept) begin
      op_nxt    = brb_op_t'(in_operation);
      wbyte_nxt = in_wr_byte;
      off_nxt   = in_rd_offset;
      len_nxt   = in_rd_length;
      del_nxt   = in_rd_delete;
    end

    iss_v_nxt    = (state_r == S_RUN);
    iss_last_nxt = (state_r == S_RUN) && (rem_r == RW'(1));

    unique case (state_r)
      S_WR: begin
        emit            = 1'b1;
        out_rd_byte_nxt = '0;
        out_last_nxt    = 1'b1;
        if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          out_status_nxt = ST_OK;
          ram_wr_en      = 1'b1;
          head_nxt       = wa_y;
          count_nxt      = count_r + CW'(1);
          emit_cnt       = count_r + CW'(1);
        end
      end
      S_CHK: begin
        wa_a = tail_r;
        wa_b = UW'(off_r);
        if (count_r == '0) begin
          emit            = 1'b1;
          out_rd_byte_nxt = '0;
          out_last_nxt    = 1'b1;
          out_status_nxt  = ST_EMPTY;
        end else if (UW'(off_r) >= UW'(count_r)) begin
          emit            = 1'b1;
          out_rd_byte_nxt = '0;
          out_last_nxt    = 1'b1;
          out_status_nxt  = ST_RANGE;
        end else begin
          idx_nxt   = wa_y;
          avail_nxt = CW'(UW'(count_r) - UW'(off_r));
        end
      end
      S_LEN: begin
        run_len_nxt = len_c;
        rem_nxt     = len_c;
        // The count drops now so that every byte of the run reports the
        // fill level as it stands after the read.
        if (del_r) begin
          count_nxt = count_r - CW'(len_c);
        end
      end
      S_RUN: begin
        ram_rd_en = 1'b1;
        wa_a      = idx_r;
        wa_b      = UW'(1);
        idx_nxt   = wa_y;
        rem_nxt   = rem_r - RW'(1);
      end
      S_END: begin
        wa_a = tail_r;
        wa_b = UW'(run_len_r);
        if (del_r) begin
          tail_nxt = wa_y;
        end
      end
      default: begin
      end
    endcase

    // Store data returns in the cycle after each issued read.
    if (iss_v_r) begin
      emit            = 1'b1;
      out_rd_byte_nxt = ram_rd_data;
      out_status_nxt  = ST_OK;
      out_last_nxt    = iss_last_r;
    end

    if (emit) begin
      out_valid_nxt      = 1'b1;
      out_is_empty_nxt   = (emit_cnt == '0);
      out_has_space_nxt  = (emit_cnt < size_r);
      out_fill_count_nxt = FILL_W'(32'(emit_cnt));
    end

    // A size write empties the ring; stored bytes are left in place.
    if (cfg_fire) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
      if (cfg_buffer_size == '0) begin
        size_nxt = CW'(1);
      end else if (32'(cfg_buffer_size) > 32'(DEPTH)) begin
        size_nxt = CW'(DEPTH);
      end else begin
        size_nxt = CW'(32'(cfg_buffer_size));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      size_r      <= CW'(DEPTH);
      iss_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      size_r      <= size_nxt;
      iss_v_r     <= iss_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r             <= op_nxt;
    wbyte_r          <= wbyte_nxt;
    off_r            <= off_nxt;
    len_r            <= len_nxt;
    del_r            <= del_nxt;
    idx_r            <= idx_nxt;
    avail_r          <= avail_nxt;
    run_len_r        <= run_len_nxt;
    rem_r            <= rem_nxt;
    iss_last_r       <= iss_last_nxt;
    out_rd_byte_r    <= out_rd_byte_nxt;
    out_status_r     <= out_status_nxt;
    out_last_r       <= out_last_nxt;
    out_is_empty_r   <= out_is_empty_nxt;
    out_has_space_r  <= out_has_space_nxt;
    out_fill_count_r <= out_fill_count_nxt;
  end

  // The latched operation code also forces out_last high on write results.
  logic op_is_read;
  assign op_is_read = (op_r == OP_READ);

  assign out_valid      = out_valid_r;
  assign out_rd_byte    = out_rd_byte_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r || (out_valid_r && !op_is_read);
  assign out_is_empty   = out_is_empty_r;
  assign out_has_space  = out_has_space_r;
  assign out_fill_count = out_fill_count_r;

endmodule

// ===== rtl/brb_ram.sv =====
module brb_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [brb_pkg::BYTE_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [brb_pkg::BYTE_W-1:0]  rd_data
);
  import brb_pkg::*;

  logic [BYTE_W-1:0] mem_r [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/brb_wrap_add.sv =====
module brb_wrap_add #(
  parameter int AW = 12,
  parameter int CW = 13,
  parameter int UW = 14
) (
  input  logic [AW-1:0] a,
  input  logic [UW-1:0] b,
  input  logic [CW-1:0] size,
  output logic [AW-1:0] y
);

  logic [UW-1:0] sum;
  logic [UW-1:0] size_ext;

  // The first operand stays below the ring size and the second never exceeds it,
  // so one conditional subtract brings the sum back into range.
  always_comb begin
    size_ext = UW'(size);
    sum      = UW'(a) + b;
    if (sum >= size_ext) begin
      y = AW'(sum - size_ext);
    end else begin
      y = AW'(sum);
    end
  end

endmodule

// ===== tb/byte_ring_buffer_with_offset_peek_core_tb.sv =====
`timescale 1ns / 100ps

// Testbench for the byte ring buffer with offset peek.
// Items are sent one at a time through the start/busy handshake. A shadow ring
// kept in this file predicts the results of every accepted item. Each strobed
// result is then compared, field by field, with the oldest prediction.
module byte_ring_buffer_with_offset_peek_core_tb;
  import brb_pkg::*;

  localparam int RING_DEPTH  = 4096;
  localparam int RUN_MAX     = 64;
  localparam int CYCLE_LIMIT = 400000;
  // The block is already idle when the last result of an item strobes; a few
  // quiet cycles before a size write keep it well clear of any transfer.
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [BYTE_W-1:0] rd_byte;
    brb_status_t       status;
    logic              last;
    logic              is_empty;
    logic              has_space;
    logic [FILL_W-1:0] fill_count;
  } ring_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_operation;
  logic [BYTE_W-1:0] in_wr_byte;
  logic [OFF_W-1:0] in_rd_offset;
  logic [LEN_W-1:0] in_rd_length;
  logic in_rd_delete;
  logic out_valid;
  logic [BYTE_W-1:0] out_rd_byte;
  brb_status_t out_status;
  logic out_last;
  logic out_is_empty;
  logic out_has_space;
  logic [FILL_W-1:0] out_fill_count;
  logic cfg_valid;
  logic cfg_ready;
  logic [SIZE_W-1:0] cfg_buffer_size;

  // Shadow copy of the ring: store, head, fill and the size register.
  logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
  int unsigned ring_head;
  int unsigned ring_fill;
  logic [SIZE_W-1:0] ring_size_reg;

  ring_result_t ring_expect_q[$];
  int mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit no_idle = 1'b0;

  byte_ring_buffer_with_offset_peek_core #(
    .DEPTH(RING_DEPTH),
    .MAX_RUN(RUN_MAX)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_operation(in_operation),
    .in_wr_byte(in_wr_byte),
    .in_rd_offset(in_rd_offset),
    .in_rd_length(in_rd_length),
    .in_rd_delete(in_rd_delete),
    .out_valid(out_valid),
    .out_rd_byte(out_rd_byte),
    .out_status(out_status),
    .out_last(out_last),
    .out_is_empty(out_is_empty),
    .out_has_space(out_has_space),
    .out_fill_count(out_fill_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_buffer_size(cfg_buffer_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The run is cut off at a generous cycle limit so a hung handshake cannot
  // keep the simulation alive forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // The size register acts as 1 when it holds zero and saturates at the depth.
  function automatic int unsigned ring_slots();
    if (ring_size_reg == '0) begin
      return 1;
    end
    if (ring_size_reg > RING_DEPTH) begin
      return RING_DEPTH;
    end
    return ring_size_reg;
  endfunction

  // Every result carries the flags and the fill count as they stand after the
  // item, so the shadow state must already be updated when this is called.
  function automatic void push_ring_result(logic [BYTE_W-1:0] rd_byte, brb_status_t status,
                                           logic last);
    ring_result_t r;
    r.rd_byte    = rd_byte;
    r.status     = status;
    r.last       = last;
    r.is_empty   = (ring_fill == 0);
    r.has_space  = (ring_fill < ring_slots());
    r.fill_count = ring_fill[FILL_W-1:0];
    ring_expect_q.push_back(r);
  endfunction

  // Works out the results of one accepted item and advances the shadow ring.
  function automatic void predict_ring_step(brb_op_t op, logic [BYTE_W-1:0] wr_byte,
                                            logic [OFF_W-1:0] rd_offset,
                                            logic [LEN_W-1:0] rd_length, logic rd_delete);
    int unsigned slots;
    int unsigned run_len;
    int unsigned idx;
    logic [BYTE_W-1:0] run_bytes [RUN_MAX];
    slots = ring_slots();
    if (op == OP_WRITE) begin
      if (ring_fill >= slots) begin
        push_ring_result('0, ST_FULL, 1'b1);
      end else begin
        ring_mem[ring_head] = wr_byte;
        ring_head = (ring_head + 1) % slots;
        ring_fill++;
        push_ring_result('0, ST_OK, 1'b1);
      end
    end else if (ring_fill == 0) begin
      push_ring_result('0, ST_EMPTY, 1'b1);
    end else if (rd_offset >= ring_fill) begin
      push_ring_result('0, ST_RANGE, 1'b1);
    end else begin
      // A zero length counts as one, anything above the run limit saturates,
      // and the run never reaches past the newest byte.
      run_len = (rd_length == 0) ? 1 : rd_length;
      if (run_len > RUN_MAX) begin
        run_len = RUN_MAX;
      end
      if (run_len > ring_fill - rd_offset) begin
        run_len = ring_fill - rd_offset;
      end
      idx = ring_head + slots - ring_fill + rd_offset;
      while (idx >= slots) begin
        idx -= slots;
      end
      for (int i = 0; i < run_len; i++) begin
        run_bytes[i] = ring_mem[idx];
        idx = (idx + 1 >= slots) ? 0 : idx + 1;
      end
      // Deletion always drops the oldest bytes, whatever the offset was.
      if (rd_delete) begin
        ring_fill -= run_len;
      end
      for (int i = 0; i < run_len; i++) begin
        push_ring_result(run_bytes[i], ST_OK, (i + 1 == run_len));
      end
    end
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Results cannot be held off, so every strobe is a transfer and is checked
  // against the oldest prediction at the edge that ends its cycle.
  always @(posedge clk) begin : result_check
    ring_result_t exp_r;
    if (rst_n && out_valid) begin
      if (ring_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual rd_byte %0h status %0d",
                 $time, out_rd_byte, out_status);
        mismatch_count++;
      end else begin
        exp_r = ring_expect_q.pop_front();
        check_field("rd_byte", exp_r.rd_byte, out_rd_byte);
        check_field("status", exp_r.status, out_status);
        check_field("last", exp_r.last, out_last);
        check_field("is_empty", exp_r.is_empty, out_is_empty);
        check_field("has_space", exp_r.has_space, out_has_space);
        check_field("fill_count", exp_r.fill_count, out_fill_count);
      end
    end
  end

  // Mostly short gaps with a few long ones; phases with no_idle set run
  // back to back.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 40) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  // Presents one item and holds it until the block takes it. With no gap to
  // follow, start stays high so the next item goes in right behind it.
  task automatic send_ring_item(brb_op_t op, logic [BYTE_W-1:0] wr_byte,
                                logic [OFF_W-1:0] rd_offset, logic [LEN_W-1:0] rd_length,
                                logic rd_delete);
    int unsigned gap;
    start        <= 1'b1;
    in_operation <= op;
    in_wr_byte   <= wr_byte;
    in_rd_offset <= rd_offset;
    in_rd_length <= rd_length;
    in_rd_delete <= rd_delete;
    do @(posedge clk); while (busy);
    predict_ring_step(op, wr_byte, rd_offset, rd_length, rd_delete);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_write(logic [BYTE_W-1:0] wr_byte);
    send_ring_item(OP_WRITE, wr_byte, OFF_W'($urandom), LEN_W'($urandom), 1'($urandom));
  endtask

  task automatic send_read(logic [OFF_W-1:0] rd_offset, logic [LEN_W-1:0] rd_length,
                           logic rd_delete);
    send_ring_item(OP_READ, BYTE_W'($urandom), rd_offset, rd_length, rd_delete);
  endtask

  // Stops sending and waits until every predicted result has been seen.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (ring_expect_q.size() != 0);
  endtask

  // The size register is only written with the block idle. The write empties
  // the ring but leaves the stored bytes in place.
  task automatic write_ring_size(logic [SIZE_W-1:0] size_val);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_buffer_size <= size_val;
    do @(posedge clk); while (!cfg_ready);
    ring_size_reg = size_val;
    ring_head     = 0;
    ring_fill     = 0;
    cfg_valid <= 1'b0;
  endtask

  // Reset defaults: a read on the empty ring, a few writes at the byte
  // extremes, then lengths of zero and above the run limit, offsets past the
  // data and deleting reads until the ring is empty again.
  task automatic test_reset_and_extremes();
    send_read(12'd0, 7'd1, 1'b0);
    send_write(8'h00);
    send_write(8'hFF);
    send_write(8'h5A);
    send_read(12'd0, 7'd0, 1'b0);
    send_read(12'd0, 7'd127, 1'b0);
    send_read(12'd3, 7'd1, 1'b0);
    send_read(12'hFFF, 7'd64, 1'b0);
    send_read(12'd2, 7'd1, 1'b1);
    send_read(12'd0, 7'd64, 1'b1);
    send_read(12'd0, 7'd1, 1'b0);
  endtask

  // A one-slot ring fills on the first write and refuses the second. A size
  // write with a byte still held must leave the ring empty. Zero acts as one.
  task automatic test_single_slot();
    write_ring_size(13'd1);
    send_write(8'hAA);
    send_write(8'h55);
    send_read(12'd0, 7'd64, 1'b1);
    send_write(8'h3C);
    write_ring_size(13'd0);
    send_read(12'd0, 7'd1, 1'b0);
    send_write(8'h11);
    send_write(8'h22);
    send_read(12'd0, 7'd64, 1'b0);
  endtask

  // The largest register value saturates to the depth. A small ring is then
  // filled, refused, partly drained and refilled so that reads wrap around.
  task automatic test_size_saturation_and_wrap();
    write_ring_size(13'h1FFF);
    send_write(8'h81);
    send_read(12'd1, 7'd1, 1'b0);
    write_ring_size(13'd3);
    send_write(8'h01);
    send_write(8'h02);
    send_write(8'h03);
    send_write(8'h04);
    send_read(12'd1, 7'd2, 1'b1);
    send_write(8'h05);
    send_write(8'h06);
    send_read(12'd0, 7'd64, 1'b0);
    send_read(12'd2, 7'd5, 1'b0);
  endtask

  // Long runs need a deep fill: one byte more than the run limit shows that a
  // long request saturates before it is clamped. A deleting read then drops the
  // oldest bytes, as many as its run holds, and a short refill carries the newest
  // bytes past the wrap point so the last runs cross it.
  task automatic test_long_runs();
    write_ring_size(13'd70);
    no_idle = 1'b0;
    repeat (65) send_write(BYTE_W'($urandom));
    send_read(12'd0, 7'd127, 1'b0);
    send_read(12'd20, 7'd64, 1'b0);
    send_read(OFF_W'($urandom_range(0, 64)), 7'd64, 1'b1);
    repeat (6) send_write(BYTE_W'($urandom));
    send_read(12'd0, 7'd64, 1'b0);
    send_read(OFF_W'($urandom_range(0, ring_fill - 1)), LEN_W'($urandom_range(1, 64)), 1'b1);
  endtask

  // The sender pauses until every result of a back-to-back burst is in.
  task automatic test_pause_until_drained();
    write_ring_size(13'd8);
    no_idle = 1'b1;
    repeat (5) send_write(BYTE_W'($urandom));
    drain_results();
    send_read(12'd1, 7'd3, 1'b0);
    send_read(12'd0, 7'd64, 1'b1);
    no_idle = 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] pick_ring_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return SIZE_W'($urandom_range(1, 16));
    end
    if (r < 80) begin
      return SIZE_W'($urandom_range(17, 100));
    end
    if (r < 88) begin
      return SIZE_W'(RING_DEPTH);
    end
    if (r < 94) begin
      return SIZE_W'($urandom_range(RING_DEPTH + 1, 8191));
    end
    return (r < 97) ? '0 : SIZE_W'($urandom_range(101, RING_DEPTH - 1));
  endfunction

  // Mostly well-formed traffic: writes while there is room, occasional writes
  // into a full ring, and reads inside the held data. The rest is noise with
  // every field random, which hits offsets past the data and odd lengths.
  task automatic send_random_item();
    brb_op_t op;
    logic [BYTE_W-1:0] wr_byte;
    logic [OFF_W-1:0] rd_offset;
    logic [LEN_W-1:0] rd_length;
    logic rd_delete;
    int unsigned slots;
    slots     = ring_slots();
    op        = brb_op_t'($urandom_range(0, 1));
    wr_byte   = BYTE_W'($urandom);
    rd_offset = OFF_W'($urandom);
    rd_length = LEN_W'($urandom);
    rd_delete = 1'($urandom);
    if ($urandom_range(0, 99) >= 15) begin
      if (ring_fill == 0) begin
        op = OP_WRITE;
      end else if (ring_fill >= slots) begin
        op = ($urandom_range(0, 99) < 85) ? OP_READ : OP_WRITE;
      end else begin
        op = ($urandom_range(0, 99) < 60) ? OP_WRITE : OP_READ;
      end
      if (op == OP_READ) begin
        rd_offset = OFF_W'($urandom_range(0, ring_fill - 1));
        rd_length = LEN_W'($urandom_range(1, RUN_MAX));
      end
    end
    send_ring_item(op, wr_byte, rd_offset, rd_length, rd_delete);
  endtask

  // Several phases, each at a fresh size; every other phase has no idling.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      write_ring_size(pick_ring_size());
      no_idle = (phase % 2 == 0);
      repeat (5) send_random_item();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_operation    = OP_WRITE;
    in_wr_byte      = '0;
    in_rd_offset    = '0;
    in_rd_length    = '0;
    in_rd_delete    = 1'b0;
    cfg_valid       = 1'b0;
    cfg_buffer_size = '0;
    ring_head       = 0;
    ring_fill       = 0;
    ring_size_reg   = SIZE_W'(RING_DEPTH);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_and_extremes();
    test_single_slot();
    test_size_saturation_and_wrap();
    test_pause_until_drained();
    test_long_runs();
    test_random_traffic();

    drain_results();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (mismatch_count == 0 && ring_expect_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/brb_pkg.sv
rtl/brb_ram.sv
rtl/brb_wrap_add.sv
rtl/byte_ring_buffer_with_offset_peek_core.sv
tb/byte_ring_buffer_with_offset_peek_core_tb.sv
